// ===== src/uartrb_pkg.sv =====
// Shared types and codes for the buffered UART ring front end.
// No dependencies.
package uartrb_pkg;

  // Request kinds carried in req_type
  localparam logic [1:0] REQ_CPU_SEND = 2'd0;
  localparam logic [1:0] REQ_CPU_READ = 2'd1;
  localparam logic [1:0] REQ_TX_DONE  = 2'd2;
  localparam logic [1:0] REQ_LINE_RX  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TX_FULL  = 2'd1;
  localparam logic [1:0] ST_RX_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       line_tx_valid;
    logic [7:0] line_tx_byte;
    logic       tx_busy;
  } rsp_item_t;

  // Per-cycle commands into one ring
  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
  } ring_ctl_t;

  // Ring occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ===== src/uartrb_ring.sv =====
// One byte ring: DEPTH-1 slots, one kept empty, registered read at tail.
// Depends on uartrb_pkg.
module uartrb_ring #(
  parameter int DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  uartrb_pkg::ring_ctl_t ctl,
  input  logic [7:0]            push_data,
  output uartrb_pkg::ring_stat_t stat,
  output logic [7:0]            rd_data
);
  import uartrb_pkg::*;

  localparam int SLOTS = DEPTH - 1;
  localparam int PW    = $clog2(SLOTS);
  localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

  logic [7:0]    mem [SLOTS];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;

  // wrap after the last slot
  assign head_inc = (head == LAST) ? '0 : head + PW'(1);
  assign tail_inc = (tail == LAST) ? '0 : tail + PW'(1);

  assign stat.empty = (head == tail);
  assign stat.full  = (head_inc == tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (ctl.push) begin
        head <= head_inc;
      end
      if (ctl.pop) begin
        tail <= tail_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[head] <= push_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[tail];
    end
  end

endmodule

// ===== src/uart_tx_rx_ring_buffers.sv =====
// Top level of the buffered UART front end: transmit and receive rings,
// request decode, result register and output skid stage.
// Depends on uartrb_pkg and uartrb_ring.
//
// Each request transfer (CPU send, CPU read, line tx done, line byte received)
// produces exactly one response transfer. The block takes one request per
// cycle while the skid register is empty, and each response is registered in
// the result register; the rate is set by a single pass through the ring
// pointer compare and update, with the ring slot read captured in a register
// at the request edge. A two-entry output (result register plus skid register)
// lets a new request transfer happen while a finished response still waits;
// req_ready drops whenever the skid register holds a response, even if the
// result register behind it is empty. Each ring has DEPTH-1 slots and holds at
// most DEPTH-2 bytes. A send that finds the transmitter idle is handed to the
// line in the same response. Ring slots need no clearing after reset.
module uart_tx_rx_ring_buffers #(
  parameter int DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  uartrb_pkg::req_item_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output uartrb_pkg::rsp_item_t rsp
);
  import uartrb_pkg::*;

  // Control part of the result register; bytes come from ring reads or bypass
  typedef struct packed {
    logic [1:0] status;
    logic       rvalid;
    logic       lvalid;
    logic       lbypass;
    logic [7:0] lbyte;
    logic       busy;
  } res_ctl_t;

  logic       accept;
  ring_ctl_t  tx_ctl;
  ring_ctl_t  rx_ctl;
  ring_stat_t tx_stat;
  ring_stat_t rx_stat;
  logic [7:0] tx_rd;
  logic [7:0] rx_rd;

  logic       tx_active;
  logic       tx_active_next;
  res_ctl_t   res_next;
  res_ctl_t   res;
  logic       res_valid;
  rsp_item_t  res_item;
  rsp_item_t  skid;
  logic       skid_valid;

  assign req_ready = !skid_valid;
  assign accept    = req_valid && req_ready;

  uartrb_ring #(.DEPTH(DEPTH)) u_tx_ring (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tx_ctl),
    .push_data (req.data_byte),
    .stat      (tx_stat),
    .rd_data   (tx_rd)
  );

  uartrb_ring #(.DEPTH(DEPTH)) u_rx_ring (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rx_ctl),
    .push_data (req.data_byte),
    .stat      (rx_stat),
    .rd_data   (rx_rd)
  );

  // Request decode: ring commands, flag update and result control
  always_comb begin
    tx_ctl         = '{push: 1'b0, pop: 1'b0, rd_en: accept};
    rx_ctl         = '{push: 1'b0, pop: 1'b0, rd_en: accept};
    tx_active_next = tx_active;
    res_next       = '0;
    res_next.lbyte = req.data_byte;
    if (accept) begin
      unique case (req.req_type)
        REQ_CPU_SEND: begin
          if (tx_stat.full) begin
            res_next.status = ST_TX_FULL;
          end else begin
            tx_ctl.push = 1'b1;
            if (!tx_active) begin
              // start the line at once; an empty ring hands over the new byte
              tx_active_next   = 1'b1;
              tx_ctl.pop       = 1'b1;
              res_next.lvalid  = 1'b1;
              res_next.lbypass = tx_stat.empty;
            end
          end
        end
        REQ_CPU_READ: begin
          if (rx_stat.empty) begin
            res_next.status = ST_RX_EMPTY;
          end else begin
            rx_ctl.pop      = 1'b1;
            res_next.rvalid = 1'b1;
          end
        end
        REQ_TX_DONE: begin
          if (tx_stat.empty) begin
            tx_active_next = 1'b0;
          end else begin
            tx_ctl.pop      = 1'b1;
            res_next.lvalid = 1'b1;
          end
        end
        REQ_LINE_RX: begin
          // full ring drops the byte silently
          rx_ctl.push = !rx_stat.full;
        end
        default: begin
        end
      endcase
    end
    res_next.busy = tx_active_next;
  end

  // Result formed from registered control and registered ring reads
  always_comb begin
    res_item.status        = res.status;
    res_item.read_valid    = res.rvalid;
    res_item.read_byte     = res.rvalid ? rx_rd : 8'd0;
    res_item.line_tx_valid = res.lvalid;
    res_item.line_tx_byte  = res.lvalid ? (res.lbypass ? res.lbyte : tx_rd) : 8'd0;
    res_item.tx_busy       = res.busy;
  end

  // Skid holds the older response; the result register waits behind it
  assign rsp_valid = skid_valid || res_valid;
  assign rsp       = skid_valid ? skid : res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_active  <= 1'b0;
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      tx_active <= tx_active_next;
      if (skid_valid) begin
        if (rsp_ready) begin
          skid_valid <= 1'b0;
        end
      end else begin
        if (res_valid && !rsp_ready) begin
          skid_valid <= 1'b1;
        end
        res_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
    if (!skid_valid && res_valid && !rsp_ready) begin
      skid <= res_item;
    end
  end

  // An idle transmitter never leaves bytes queued
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !tx_active |-> tx_stat.empty)
    else $error("transmit ring holds bytes while transmitter idle");

  // Handing a byte to the line means the transmitter is active
  a_line_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.line_tx_valid) |-> rsp.tx_busy)
    else $error("line byte issued with transmitter idle");

  // A rejected send touches nothing else
  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_TX_FULL) |->
      (!rsp.line_tx_valid && !rsp.read_valid && rsp.tx_busy))
    else $error("rejected send produced output");

  // In the cycle after a request transfer, a response is valid at the output
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("response missing after request transfer");

endmodule

// ===== test/tb_uart_tx_rx_ring_buffers.sv =====
// Testbench for uart_tx_rx_ring_buffers: random and directed request traffic
// checked against an in-bench model of the transmit and receive byte rings.
// Depends on uartrb_pkg and the uart_tx_rx_ring_buffers RTL.
module tb_uart_tx_rx_ring_buffers;
  timeunit 1ns;
  timeprecision 1ps;

  import uartrb_pkg::*;

  localparam int RING_DEPTH   = 32;
  localparam int RING_SLOTS   = RING_DEPTH - 1;  // one slot always kept empty
  localparam int RANDOM_REQS  = 800;
  localparam int MAX_BURST    = 40;              // longer than a full ring
  localparam int STALL_LIMIT  = 2000;            // cycles with no transfer at all
  localparam int DRAIN_CYCLES = 10;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  uart_tx_rx_ring_buffers #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ring model. Write pointer and read pointer per ring, plus the transmit
  // active flag. Pointers wrap after the last usable slot.
  // ---------------------------------------------------------------------------
  logic [7:0] tx_ring [RING_SLOTS];
  logic [7:0] rx_ring [RING_SLOTS];
  int         tx_wr     = 0;
  int         tx_rd     = 0;
  int         rx_wr     = 0;
  int         rx_rd     = 0;
  logic       tx_active = 1'b0;

  function automatic int ring_step(int p);
    return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
  endfunction

  // Hands the next queued byte to the line, or drops the active flag when
  // nothing is left to send.
  function automatic void launch_next_tx(ref rsp_item_t r);
    if (tx_wr != tx_rd) begin
      r.line_tx_valid = 1'b1;
      r.line_tx_byte  = tx_ring[tx_rd];
      tx_rd           = ring_step(tx_rd);
    end else begin
      tx_active = 1'b0;
    end
  endfunction

  // Applies one request to the ring model and returns the response it gives.
  function automatic rsp_item_t predict_ring_response(req_item_t item);
    rsp_item_t r;
    r = '0;
    case (item.req_type)
      REQ_CPU_SEND: begin
        if (ring_step(tx_wr) == tx_rd) begin
          r.status = ST_TX_FULL;
        end else begin
          tx_ring[tx_wr] = item.data_byte;
          tx_wr          = ring_step(tx_wr);
          // idle transmitter: the byte goes to the line in this same response
          if (!tx_active) begin
            tx_active = 1'b1;
            launch_next_tx(r);
          end
        end
      end
      REQ_CPU_READ: begin
        if (rx_wr == rx_rd) begin
          r.status = ST_RX_EMPTY;
        end else begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_ring[rx_rd];
          rx_rd        = ring_step(rx_rd);
        end
      end
      REQ_TX_DONE: begin
        launch_next_tx(r);
      end
      default: begin
        // line byte into a full receive ring is lost without any status
        if (ring_step(rx_wr) != rx_rd) begin
          rx_ring[rx_wr] = item.data_byte;
          rx_wr          = ring_step(rx_wr);
        end
      end
    endcase
    r.tx_busy = tx_active;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // ---------------------------------------------------------------------------
  req_item_t pending_reqs[$];
  rsp_item_t expected_rsps[$];
  int        total_reqs    = 0;
  int        reqs_issued   = 0;   // driver side: items put on the request port
  int        reqs_accepted = 0;   // monitor side: request transfers seen
  int        error_count   = 0;
  int        quiet_cycles  = 0;

  task automatic add_req(logic [1:0] kind, logic [7:0] data);
    req_item_t item;
    item.req_type  = kind;
    item.data_byte = data;
    pending_reqs.push_back(item);
  endtask

  task automatic add_burst(logic [1:0] kind, int len);
    for (int i = 0; i < len; i++) add_req(kind, 8'($urandom_range(0, 255)));
  endtask

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Idle mix by run phase: first third sender idles 29% and receiver 71%,
  // second third the other way round, last third no idling at all.
  function automatic int sender_idle_pct();
    if (reqs_accepted * 3 < total_reqs) return 29;
    if (reqs_accepted * 3 < total_reqs * 2) return 71;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (reqs_accepted * 3 < total_reqs) return 71;
    if (reqs_accepted * 3 < total_reqs * 2) return 29;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A request that is up stays up
  // until the monitor has counted its transfer.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
    end else begin
      if (!req_valid || reqs_accepted == reqs_issued) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          req         <= pending_reqs.pop_front();
          req_valid   <= 1'b1;
          reqs_issued <= reqs_issued + 1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Predictions are made
  // in request order, responses are matched oldest first.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    rsp_item_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(predict_ring_response(req));
        reqs_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report_error("response transfer with nothing outstanding");
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", rsp.status, want.status);
          check_field("read_valid", rsp.read_valid, want.read_valid);
          check_field("read_byte", rsp.read_byte, want.read_byte);
          check_field("line_tx_valid", rsp.line_tx_valid, want.line_tx_valid);
          check_field("line_tx_byte", rsp.line_tx_byte, want.line_tx_byte);
          check_field("tx_busy", rsp.tx_busy, want.tx_busy);
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin : dog
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    int pick;
    // Directed: empty read, tx done while idle, send while idle and while
    // active, drain of the transmit ring, line bytes at both extremes and their reads.
    add_req(REQ_CPU_READ, 8'h00);
    add_req(REQ_TX_DONE, 8'h00);
    add_req(REQ_CPU_SEND, 8'h00);
    add_req(REQ_CPU_SEND, 8'hFF);
    add_req(REQ_CPU_SEND, 8'hA5);
    add_req(REQ_TX_DONE, 8'h00);
    add_req(REQ_TX_DONE, 8'hFF);
    add_req(REQ_TX_DONE, 8'h00);
    add_req(REQ_TX_DONE, 8'h00);
    add_req(REQ_LINE_RX, 8'h00);
    add_req(REQ_LINE_RX, 8'hFF);
    add_req(REQ_LINE_RX, 8'h5A);
    add_req(REQ_CPU_READ, 8'hFF);
    add_req(REQ_CPU_READ, 8'h00);
    add_req(REQ_CPU_READ, 8'h00);
    add_req(REQ_CPU_READ, 8'h00);

    // Random: mostly bursts of one kind so both rings run full and empty,
    // mixed with short runs of arbitrary requests.
    while (pending_reqs.size() < RANDOM_REQS + 16) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1:    add_burst(REQ_CPU_SEND, $urandom_range(1, MAX_BURST));
        2, 3:    add_burst(REQ_TX_DONE, $urandom_range(1, MAX_BURST));
        4, 5:    add_burst(REQ_LINE_RX, $urandom_range(1, MAX_BURST));
        6, 7:    add_burst(REQ_CPU_READ, $urandom_range(1, MAX_BURST));
        default: begin
          repeat ($urandom_range(1, 8))
            add_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      endcase
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    // any stray response would show up in this window
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_rsps.size() != 0)
      report_error($sformatf("%0d responses never arrived", expected_rsps.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/uartrb_pkg.sv
src/uartrb_ring.sv
src/uart_tx_rx_ring_buffers.sv
test/tb_uart_tx_rx_ring_buffers.sv
